[sv/ght_pkg.sv]
// shared types, request/result layouts and codes for the generational handle table
// no dependencies
package ght_pkg;

    // default sizes, handed to the top level parameters
    localparam int SLOT_COUNT_DEF   = 256;
    localparam int SERIAL_LIMIT_DEF = 256;
    localparam int TYPE_COUNT_DEF   = 16;

    // operation codes
    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_EXACT  = 2'd1;
    localparam logic [1:0] MODE_MASK   = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_TYPE  = 3'd1;
    localparam logic [2:0] ST_RANGE = 3'd2;
    localparam logic [2:0] ST_STALE = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_OWNER = 3'd5;

    // stream widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] entity_tag;
        logic        handle_valid;
        logic [3:0]  type_code;
        logic [3:0]  wanted_type;
        logic [15:0] type_mask;
        logic [7:0]  handle_index;
        logic [7:0]  handle_serial;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_tag;
        logic [3:0]  new_type;
        logic [7:0]  new_index;
        logic [7:0]  new_serial;
    } t_res;

    // bookkeeping commands from the decision logic to the allocator state
    typedef struct packed {
        logic pop;
        logic push;
        logic grow;
        logic serial_we;
    } t_alloc_cmd;

endpackage

[sv/ght_slot_store.sv]
// slot memory: tag, serial and live flag per slot, one read and one write port
// depends on ght_pkg
module ght_slot_store
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int SERIAL_LIMIT = SERIAL_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rd_en,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_rd_addr,
    output logic [31:0]                     o_rd_tag,
    output logic [$clog2(SERIAL_LIMIT)-1:0] o_rd_serial,
    output logic                            o_rd_live,
    input  logic                            i_we,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_wr_addr,
    input  logic [31:0]                     i_wr_tag,
    input  logic [$clog2(SERIAL_LIMIT)-1:0] i_wr_serial,
    input  logic                            i_wr_live
);

    localparam int SW = $clog2(SERIAL_LIMIT);
    localparam int WW = SW + 33;

    logic [WW-1:0] r_mem [SLOT_COUNT];
    logic [WW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= {i_wr_live, i_wr_serial, i_wr_tag};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_tag    = r_rd[31:0];
    assign o_rd_serial = r_rd[SW+31:32];
    assign o_rd_live   = r_rd[WW-1];

endmodule

[sv/ght_alloc.sv]
// allocator state: lifo free stack memory, free count, high-water mark, serial counter
// depends on ght_pkg
module ght_alloc
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int SERIAL_LIMIT = SERIAL_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  t_alloc_cmd                      i_cmd,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_push_idx,
    input  logic [$clog2(SERIAL_LIMIT)-1:0] i_push_serial,
    input  logic [$clog2(SERIAL_LIMIT)-1:0] i_next_serial,
    output logic [$clog2(SLOT_COUNT)-1:0]   o_top_idx,
    output logic [$clog2(SERIAL_LIMIT)-1:0] o_top_serial,
    output logic [$clog2(SLOT_COUNT+1)-1:0] o_free_count,
    output logic [$clog2(SLOT_COUNT+1)-1:0] o_high_water,
    output logic [$clog2(SERIAL_LIMIT)-1:0] o_next_serial
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = $clog2(SERIAL_LIMIT);

    // each entry keeps the freed slot and the serial it held when freed
    logic [SW+IW-1:0] r_stack [SLOT_COUNT];
    logic [SW+IW-1:0] r_top;
    logic [CW-1:0]    r_free_count;
    logic [CW-1:0]    r_high_water;
    logic [SW-1:0]    r_next_serial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_stack[IW'(r_free_count)] <= {i_push_serial, i_push_idx};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_stack[IW'(r_free_count - CW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_count  <= '0;
            r_high_water  <= '0;
            r_next_serial <= '0;
        end else begin
            if (i_cmd.pop) begin
                r_free_count <= r_free_count - CW'(1);
            end else if (i_cmd.push) begin
                r_free_count <= r_free_count + CW'(1);
            end
            if (i_cmd.grow) begin
                r_high_water <= r_high_water + CW'(1);
            end
            if (i_cmd.serial_we) begin
                r_next_serial <= i_next_serial;
            end
        end
    end

    assign o_top_idx     = r_top[IW-1:0];
    assign o_top_serial  = r_top[SW+IW-1:IW];
    assign o_free_count  = r_free_count;
    assign o_high_water  = r_high_water;
    assign o_next_serial = r_next_serial;

endmodule

[sv/ght_decide.sv]
// decision logic: checks one request against the read slot and allocator state,
// forms the result and the memory and bookkeeping updates; depends on ght_pkg
module ght_decide
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int SERIAL_LIMIT = SERIAL_LIMIT_DEF,
    parameter int TYPE_COUNT   = TYPE_COUNT_DEF
) (
    input  logic                            i_fire,
    input  t_req                            i_req,
    input  logic [31:0]                     i_rd_tag,
    input  logic [$clog2(SERIAL_LIMIT)-1:0] i_rd_serial,
    input  logic                            i_rd_live,
    input  logic [$clog2(SLOT_COUNT)-1:0]   i_top_idx,
    input  logic [$clog2(SERIAL_LIMIT)-1:0] i_top_serial,
    input  logic [$clog2(SLOT_COUNT+1)-1:0] i_free_count,
    input  logic [$clog2(SLOT_COUNT+1)-1:0] i_high_water,
    input  logic [$clog2(SERIAL_LIMIT)-1:0] i_next_serial,
    output t_res                            o_res,
    output logic                            o_we,
    output logic [$clog2(SLOT_COUNT)-1:0]   o_wr_addr,
    output logic [31:0]                     o_wr_tag,
    output logic [$clog2(SERIAL_LIMIT)-1:0] o_wr_serial,
    output logic                            o_wr_live,
    output t_alloc_cmd                      o_cmd,
    output logic [$clog2(SLOT_COUNT)-1:0]   o_push_idx,
    output logic [$clog2(SERIAL_LIMIT)-1:0] o_push_serial,
    output logic [$clog2(SERIAL_LIMIT)-1:0] o_next_serial
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int SW = $clog2(SERIAL_LIMIT);

    function automatic logic [SW-1:0] bump(input logic [SW-1:0] s);
        logic [31:0] inc;
        inc = 32'(s) + 32'd1;
        return (inc == 32'(SERIAL_LIMIT)) ? '0 : SW'(inc);
    endfunction

    logic [IW-1:0] hidx;
    logic          in_range;
    logic          type_ok;
    logic [IW-1:0] alloc_idx;
    logic [SW-1:0] alloc_serial;

    assign hidx     = IW'(32'(i_req.handle_index));
    assign in_range = 32'(i_req.handle_index) < 32'(i_high_water);

    always_comb begin
        if (32'(i_req.type_code) >= 32'(TYPE_COUNT)) begin
            type_ok = 1'b0;
        end else if (i_req.mode == MODE_EXACT) begin
            type_ok = (i_req.type_code == i_req.wanted_type);
        end else begin
            type_ok = i_req.type_mask[i_req.type_code];
        end
    end

    always_comb begin
        o_res         = '0;
        o_we          = 1'b0;
        o_wr_addr     = hidx;
        o_wr_tag      = i_rd_tag;
        o_wr_serial   = i_rd_serial;
        o_wr_live     = 1'b0;
        o_cmd         = '0;
        o_push_idx    = hidx;
        o_push_serial = i_rd_serial;
        o_next_serial = i_next_serial;
        alloc_idx     = i_top_idx;
        alloc_serial  = i_next_serial;

        unique case (i_req.mode)
            MODE_ALLOC: begin
                priority if (i_free_count != '0) begin
                    o_cmd.pop = 1'b1;
                    alloc_idx = i_top_idx;
                    // skip the serial the reused slot carried before
                    alloc_serial = (i_top_serial == i_next_serial) ?
                                   bump(i_next_serial) : i_next_serial;
                end else if (32'(i_high_water) < 32'(SLOT_COUNT)) begin
                    o_cmd.grow = 1'b1;
                    alloc_idx  = IW'(i_high_water);
                end else begin
                    o_res.status = ST_FULL;
                end
                if (o_res.status == ST_OK) begin
                    o_we            = 1'b1;
                    o_wr_addr       = alloc_idx;
                    o_wr_tag        = i_req.entity_tag;
                    o_wr_serial     = alloc_serial;
                    o_wr_live       = 1'b1;
                    o_cmd.serial_we = 1'b1;
                    o_next_serial   = bump(alloc_serial);
                    o_res.new_type   = i_req.type_code;
                    o_res.new_index  = 8'(32'(alloc_idx));
                    o_res.new_serial = 8'(32'(alloc_serial));
                end
            end
            MODE_EXACT, MODE_MASK: begin
                priority if (!type_ok) begin
                    o_res.status = ST_TYPE;
                end else if (!in_range) begin
                    o_res.status = ST_RANGE;
                end else if (!i_rd_live ||
                             32'(i_rd_serial) != 32'(i_req.handle_serial)) begin
                    o_res.status = ST_STALE;
                end else begin
                    o_res.found_tag = i_rd_tag;
                end
            end
            MODE_REMOVE: begin
                priority if (!i_req.handle_valid) begin
                    o_res.status = ST_OWNER;
                end else if (!in_range) begin
                    o_res.status = ST_RANGE;
                end else if (!i_rd_live) begin
                    o_res.status = ST_STALE;
                end else if (i_rd_tag != i_req.entity_tag) begin
                    o_res.status = ST_OWNER;
                end else begin
                    o_we       = 1'b1;
                    o_cmd.push = 32'(i_free_count) < 32'(SLOT_COUNT);
                end
            end
        endcase

        if (!i_fire) begin
            o_we  = 1'b0;
            o_cmd = '0;
        end
    end

endmodule

[sv/generational_handle_table.sv]
// generational handle table top level: stream ports, request and result registers
// depends on ght_pkg, ght_slot_store, ght_alloc, ght_decide
//
// hands out handles (type, slot index, generation serial) from a table of SLOT_COUNT
// slots, looks them up by exact type or by a type mask, and removes them when the
// caller's tag matches. freed slots are reused last-freed-first; a fresh serial comes
// from a counter that wraps at SERIAL_LIMIT and skips the serial the reused slot held
// before, so an old handle to that slot reads as stale. a request is first loaded
// while the slot memory and the top of the free stack are read; then the decide step
// decides, writes back and loads the result register. the result waits
// in its own register, so the next request is taken while it is still pending; while
// the result stalls, that next request waits in the decide step and the request side
// stays not ready until the result is taken. no clearing pass is needed after reset:
// only slots below the high-water mark and stack entries below the free count are
// ever used. a full table answers status 4 and changes nothing.
module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
    parameter int SERIAL_LIMIT = SERIAL_LIMIT_DEF,
    parameter int TYPE_COUNT   = TYPE_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // entity_tag[31:0], handle_valid[32], type_code[36:33], wanted_type[40:37],
    // type_mask[56:41], handle_index[64:57], handle_serial[72:65], zero fill
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // mode[1:0]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // found_tag[31:0], new_type[35:32], new_index[43:36], new_serial[51:44], zero fill
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int SW = $clog2(SERIAL_LIMIT);

    t_req        in_req;
    t_req        r_req;
    t_res        n_res;
    t_res        r_res;
    logic        r_busy;
    logic        r_out_valid;
    logic        accept;
    logic        fire;

    // slot memory signals
    logic [31:0]   rd_tag;
    logic [SW-1:0] rd_serial;
    logic          rd_live;
    logic          we;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_tag;
    logic [SW-1:0] wr_serial;
    logic          wr_live;

    // allocator signals
    t_alloc_cmd    cmd;
    logic [IW-1:0] push_idx;
    logic [SW-1:0] push_serial;
    logic [SW-1:0] next_serial_new;
    logic [IW-1:0] top_idx;
    logic [SW-1:0] top_serial;
    logic [CW-1:0] free_count;
    logic [CW-1:0] high_water;
    logic [SW-1:0] next_serial;

    // unpack the incoming request
    assign in_req.mode          = i_s_axis_tuser[1:0];
    assign in_req.entity_tag    = i_s_axis_tdata[31:0];
    assign in_req.handle_valid  = i_s_axis_tdata[32];
    assign in_req.type_code     = i_s_axis_tdata[36:33];
    assign in_req.wanted_type   = i_s_axis_tdata[40:37];
    assign in_req.type_mask     = i_s_axis_tdata[56:41];
    assign in_req.handle_index  = i_s_axis_tdata[64:57];
    assign in_req.handle_serial = i_s_axis_tdata[72:65];

    // take a request whenever no request sits in the decide step
    assign o_s_axis_tready = !r_busy;
    assign accept          = i_s_axis_tvalid && !r_busy;
    // decide once the result register is free or being emptied
    assign fire            = r_busy && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= in_req;
        end
        if (fire) begin
            r_res <= n_res;
        end
    end

    ght_slot_store #(
        .SLOT_COUNT   (SLOT_COUNT),
        .SERIAL_LIMIT (SERIAL_LIMIT)
    ) u_slots (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr   (IW'(32'(in_req.handle_index))),
        .o_rd_tag    (rd_tag),
        .o_rd_serial (rd_serial),
        .o_rd_live   (rd_live),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_tag    (wr_tag),
        .i_wr_serial (wr_serial),
        .i_wr_live   (wr_live)
    );

    ght_alloc #(
        .SLOT_COUNT   (SLOT_COUNT),
        .SERIAL_LIMIT (SERIAL_LIMIT)
    ) u_alloc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_en       (accept),
        .i_cmd         (cmd),
        .i_push_idx    (push_idx),
        .i_push_serial (push_serial),
        .i_next_serial (next_serial_new),
        .o_top_idx     (top_idx),
        .o_top_serial  (top_serial),
        .o_free_count  (free_count),
        .o_high_water  (high_water),
        .o_next_serial (next_serial)
    );

    ght_decide #(
        .SLOT_COUNT   (SLOT_COUNT),
        .SERIAL_LIMIT (SERIAL_LIMIT),
        .TYPE_COUNT   (TYPE_COUNT)
    ) u_decide (
        .i_fire        (fire),
        .i_req         (r_req),
        .i_rd_tag      (rd_tag),
        .i_rd_serial   (rd_serial),
        .i_rd_live     (rd_live),
        .i_top_idx     (top_idx),
        .i_top_serial  (top_serial),
        .i_free_count  (free_count),
        .i_high_water  (high_water),
        .i_next_serial (next_serial),
        .o_res         (n_res),
        .o_we          (we),
        .o_wr_addr     (wr_addr),
        .o_wr_tag      (wr_tag),
        .o_wr_serial   (wr_serial),
        .o_wr_live     (wr_live),
        .o_cmd         (cmd),
        .o_push_idx    (push_idx),
        .o_push_serial (push_serial),
        .o_next_serial (next_serial_new)
    );

    // pack the result
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_res.status;
    assign o_m_axis_tdata  = {4'b0, r_res.new_serial, r_res.new_index,
                              r_res.new_type, r_res.found_tag};

endmodule

[sv/ght_checker.sv]
// port-level checks for the generational handle table, bound to the top level
// depends on ght_pkg and generational_handle_table
module ght_checker
    import ght_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    // a taken request occupies the decide step in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request taken while previous one still being decided");

    // a new result only follows a cycle spent deciding
    a_result_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result appeared without a request being decided");

    // failed requests carry no tag and no new handle
    a_error_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("failed request returned a nonzero payload");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
